// ===== src/bq_pkg.sv =====
// Shared types, widths and codes of the biquad filter.
package bq_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int CHAN_W       = 3;
    localparam int SAMPLE_W     = 24;
    localparam int COEF_W       = 32;
    localparam int STATE_W      = 32;
    localparam int ACC_W        = 36;
    localparam int EXTRA_W      = STATE_W + 1;
    localparam int CFG_IDX_W    = 3;
    localparam int CNT_W        = $clog2(SAMPLE_W);

    localparam logic [CNT_W-1:0] LAST_BIT  = CNT_W'(SAMPLE_W - 1);
    localparam logic [CNT_W-1:0] ROUND_BIT = CNT_W'(SAMPLE_W - 2);

    localparam logic [CFG_IDX_W-1:0] CFG_FEED_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEED_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FEED_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_2 = 3'd4;

    localparam logic [COEF_W-1:0] FEED_0_RESET = 32'h1000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FEED,
        ST_YSAT,
        ST_BACK,
        ST_STORE
    } bq_state_t;

    typedef struct packed {
        logic [CHAN_W-1:0]          chan_index;
        logic signed [SAMPLE_W-1:0] in_sample;
    } bq_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0]          out_chan;
        logic signed [SAMPLE_W-1:0] out_sample;
        logic                       clipped;
    } bq_out_t;

    typedef struct packed {
        logic clear;
        logic step;
        logic x_bit;
        logic y_bit;
        logic sign_step;
    } mac_ctrl_t;

endpackage

// ===== src/bq_stream_if.sv =====
// Valid/ready stream channel carrying one payload item.
interface bq_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/bq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [AW-1:0]        raddr,
    output logic [WIDTH-1:0]     rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== src/bq_serial_mac.sv =====
// Bit-serial multiply-accumulate: two serial multipliers against parallel coefficients.
module bq_serial_mac (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bq_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [bq_pkg::COEF_W-1:0]   coef_x,
    input  logic signed [bq_pkg::COEF_W-1:0]   coef_y,
    input  logic signed [bq_pkg::EXTRA_W-1:0]  extra,
    output logic signed [bq_pkg::ACC_W-1:0]    acc,
    output logic                               low_bit
);
    logic signed [bq_pkg::ACC_W-1:0] acc_reg;
    logic                            low_bit_reg;
    logic signed [bq_pkg::ACC_W-1:0] coef_x_ext;
    logic signed [bq_pkg::ACC_W-1:0] coef_y_ext;
    logic signed [bq_pkg::ACC_W-1:0] extra_ext;
    logic signed [bq_pkg::ACC_W-1:0] term_x;
    logic signed [bq_pkg::ACC_W-1:0] term_y;
    logic signed [bq_pkg::ACC_W-1:0] sum;

    assign coef_x_ext = bq_pkg::ACC_W'(coef_x);
    assign coef_y_ext = bq_pkg::ACC_W'(coef_y);
    assign extra_ext  = bq_pkg::ACC_W'(extra);

    // The sign bit of a two's complement multiplier carries negative weight.
    // The y product enters with a minus sign.
    always_comb
    begin
        term_x = '0;
        term_y = '0;
        if (ctrl.x_bit)
        begin
            term_x = ctrl.sign_step ? -coef_x_ext : coef_x_ext;
        end
        if (ctrl.y_bit)
        begin
            term_y = ctrl.sign_step ? coef_y_ext : -coef_y_ext;
        end
        sum = acc_reg + term_x + term_y + extra_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            low_bit_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            acc_reg     <= '0;
            low_bit_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            acc_reg     <= sum >>> 1;
            low_bit_reg <= sum[0];
        end
    end

    assign acc     = acc_reg;
    assign low_bit = low_bit_reg;
endmodule

// ===== src/biquad_iir_filter.sv =====
// Biquad IIR filter top level, transposed direct form II, one delay pair per channel.
//
//  channel     dir  handshake          payload
//  sample_ch   in   valid / ready      chan_index[2:0], in_sample[23:0] (Q0.23)
//  result_ch   out  valid / ready      out_chan[2:0], out_sample[23:0], clipped
//  cfg port    in   cfg_wr_en only     cfg_index[2:0], cfg_data[31:0] (Q3.28 coefficients)
//
//  An item steps through accept, one RAM read, a serial pass for the output
//  term, one saturation step, a serial pass for both state updates, one store.
//  Serial passes come from the bit-serial MACs, which consume one sample bit a cycle.
//  An item on a channel at or above CHANNELS goes straight to store and touches no state.
//  Reset clears coefficients to unity gain and marks every delay pair as zero.
//  A result waiting on result_ch does not block the next accept; the store stage
//  holds only while the output register is still full.
module biquad_iir_filter #(
    parameter int CHANNELS = bq_pkg::CHANNELS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [bq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bq_pkg::COEF_W-1:0]        cfg_data,
    bq_stream_if.sink                        sample_ch,
    bq_stream_if.source                      result_ch
);
    localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW     = bq_pkg::SAMPLE_W;
    localparam int ZW     = bq_pkg::STATE_W;
    localparam int AW_ACC = bq_pkg::ACC_W;

    // Coefficient registers
    logic signed [bq_pkg::COEF_W-1:0] coef_feed_0_reg;
    logic signed [bq_pkg::COEF_W-1:0] coef_feed_1_reg;
    logic signed [bq_pkg::COEF_W-1:0] coef_feed_2_reg;
    logic signed [bq_pkg::COEF_W-1:0] coef_back_1_reg;
    logic signed [bq_pkg::COEF_W-1:0] coef_back_2_reg;

    // Control
    bq_pkg::bq_state_t          state_reg;
    bq_pkg::bq_state_t          state_next;
    logic [bq_pkg::CNT_W-1:0]   bit_cnt_reg;
    logic [CHANNELS-1:0]        chan_valid_reg;
    logic                       skip_reg;
    logic                       zvalid_reg;
    logic                       clip_reg;
    logic                       out_valid_reg;

    // Payload
    logic [bq_pkg::CHAN_W-1:0]  chan_reg;
    logic signed [SW-1:0]       sample_reg;
    logic [SW-1:0]              x_sr_reg;
    logic [SW-1:0]              y_sr_reg;
    logic signed [SW-1:0]       y_reg;
    logic signed [ZW-1:0]       z1_reg;
    logic signed [ZW-1:0]       z2_reg;
    logic [bq_pkg::CHAN_W-1:0]  out_chan_reg;
    logic signed [SW-1:0]       out_sample_reg;
    logic                       out_clip_reg;

    // Handshake and sequencing strobes
    logic                       in_ready;
    logic                       accept;
    logic                       chan_oor;
    logic                       load_z;
    logic                       finish_y;
    logic                       store_fire;
    logic                       last_bit;
    bq_pkg::mac_ctrl_t          mac_a_ctrl;
    bq_pkg::mac_ctrl_t          mac_b_ctrl;

    // MAC operands and results
    logic signed [bq_pkg::COEF_W-1:0]  coef_a_x;
    logic signed [bq_pkg::COEF_W-1:0]  coef_a_y;
    logic signed [bq_pkg::EXTRA_W-1:0] extra_a;
    logic signed [bq_pkg::EXTRA_W-1:0] extra_b;
    logic signed [AW_ACC-1:0]          acc_a;
    logic signed [AW_ACC-1:0]          acc_b;
    logic                              low_a;
    logic                              low_b;

    // Saturation
    logic [AW_ACC-SW-4:0]   y_top;
    logic                   y_ovf;
    logic signed [SW-1:0]   y_sat;
    logic [AW_ACC-ZW+1:0]   z1_top;
    logic [AW_ACC-ZW+1:0]   z2_top;
    logic                   z1_ovf;
    logic                   z2_ovf;
    logic signed [ZW-1:0]   z1_sat;
    logic signed [ZW-1:0]   z2_sat;

    // RAM
    logic [AW-1:0]          in_addr;
    logic [AW-1:0]          st_addr;
    logic [2*ZW-1:0]        ram_rdata;

    assign accept   = sample_ch.valid && in_ready;
    assign chan_oor = 32'(sample_ch.data.chan_index) >= 32'(CHANNELS);
    assign in_addr  = AW'(sample_ch.data.chan_index);
    assign st_addr  = AW'(chan_reg);
    assign last_bit = bit_cnt_reg == bq_pkg::LAST_BIT;

    // ---------------------------------------------------------------
    // Configuration writes; an index beyond the list is dropped
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_feed_0_reg <= bq_pkg::FEED_0_RESET;
            coef_feed_1_reg <= '0;
            coef_feed_2_reg <= '0;
            coef_back_1_reg <= '0;
            coef_back_2_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                bq_pkg::CFG_FEED_0: coef_feed_0_reg <= cfg_data;
                bq_pkg::CFG_FEED_1: coef_feed_1_reg <= cfg_data;
                bq_pkg::CFG_FEED_2: coef_feed_2_reg <= cfg_data;
                bq_pkg::CFG_BACK_1: coef_back_1_reg <= cfg_data;
                bq_pkg::CFG_BACK_2: coef_back_2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bq_pkg::ST_IDLE:
            begin
                if (sample_ch.valid)
                begin
                    state_next = chan_oor ? bq_pkg::ST_STORE : bq_pkg::ST_LOAD;
                end
            end
            bq_pkg::ST_LOAD:  state_next = bq_pkg::ST_FEED;
            bq_pkg::ST_FEED:
            begin
                if (last_bit)
                begin
                    state_next = bq_pkg::ST_YSAT;
                end
            end
            bq_pkg::ST_YSAT:  state_next = bq_pkg::ST_BACK;
            bq_pkg::ST_BACK:
            begin
                if (last_bit)
                begin
                    state_next = bq_pkg::ST_STORE;
                end
            end
            bq_pkg::ST_STORE:
            begin
                if (!out_valid_reg || result_ch.ready)
                begin
                    state_next = bq_pkg::ST_IDLE;
                end
            end
            default: state_next = bq_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs
    // MAC A forms y in the feed pass, then z1' in the back pass.
    // MAC B forms z2' in the back pass only.
    // ---------------------------------------------------------------
    always_comb
    begin
        in_ready   = 1'b0;
        load_z     = 1'b0;
        finish_y   = 1'b0;
        store_fire = 1'b0;
        mac_a_ctrl = '0;
        mac_b_ctrl = '0;
        coef_a_x   = coef_feed_0_reg;
        coef_a_y   = '0;
        extra_a    = '0;
        extra_b    = '0;
        case (state_reg)
            bq_pkg::ST_IDLE:  in_ready = 1'b1;
            bq_pkg::ST_LOAD:
            begin
                load_z           = 1'b1;
                mac_a_ctrl.clear = 1'b1;
            end
            bq_pkg::ST_FEED:
            begin
                mac_a_ctrl.step      = 1'b1;
                mac_a_ctrl.x_bit     = x_sr_reg[0];
                mac_a_ctrl.sign_step = last_bit;
                // z1 weighs 2^23 in the product domain; add the rounding half with it
                if (last_bit)
                begin
                    extra_a = bq_pkg::EXTRA_W'(z1_reg) + bq_pkg::EXTRA_W'(16);
                end
            end
            bq_pkg::ST_YSAT:
            begin
                finish_y         = 1'b1;
                mac_a_ctrl.clear = 1'b1;
                mac_b_ctrl.clear = 1'b1;
            end
            bq_pkg::ST_BACK:
            begin
                coef_a_x             = coef_feed_1_reg;
                coef_a_y             = coef_back_1_reg;
                mac_a_ctrl.step      = 1'b1;
                mac_a_ctrl.x_bit     = x_sr_reg[0];
                mac_a_ctrl.y_bit     = y_sr_reg[0];
                mac_a_ctrl.sign_step = last_bit;
                mac_b_ctrl           = mac_a_ctrl;
                // Rounding half of the state LSB sits at 2^22
                if (bit_cnt_reg == bq_pkg::ROUND_BIT)
                begin
                    extra_a = bq_pkg::EXTRA_W'(1);
                    extra_b = bq_pkg::EXTRA_W'(1);
                end
                if (last_bit)
                begin
                    extra_a = bq_pkg::EXTRA_W'(z2_reg);
                end
            end
            bq_pkg::ST_STORE: store_fire = !out_valid_reg || result_ch.ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bq_pkg::ST_IDLE;
            bit_cnt_reg    <= '0;
            chan_valid_reg <= '0;
            skip_reg       <= 1'b0;
            zvalid_reg     <= 1'b0;
            clip_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_z || finish_y)
            begin
                bit_cnt_reg <= '0;
            end
            else if (mac_a_ctrl.step)
            begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end
            if (accept)
            begin
                skip_reg   <= chan_oor;
                zvalid_reg <= chan_valid_reg[in_addr];
                clip_reg   <= 1'b0;
            end
            else if (finish_y)
            begin
                clip_reg <= y_ovf;
            end
            if (store_fire && !skip_reg)
            begin
                chan_valid_reg[st_addr] <= 1'b1;
            end
            if (store_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload path: serial operand shifters, delay values, result
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            chan_reg   <= sample_ch.data.chan_index;
            sample_reg <= sample_ch.data.in_sample;
            x_sr_reg   <= sample_ch.data.in_sample;
        end
        else if (finish_y)
        begin
            x_sr_reg <= sample_reg;
        end
        else if (mac_a_ctrl.step)
        begin
            x_sr_reg <= x_sr_reg >> 1;
        end

        if (finish_y)
        begin
            y_reg    <= y_sat;
            y_sr_reg <= y_sat;
        end
        else if (mac_a_ctrl.step)
        begin
            y_sr_reg <= y_sr_reg >> 1;
        end

        // A channel never written since reset reads as zero state
        if (load_z)
        begin
            z1_reg <= zvalid_reg ? $signed(ram_rdata[ZW-1:0]) : '0;
            z2_reg <= zvalid_reg ? $signed(ram_rdata[2*ZW-1:ZW]) : '0;
        end

        if (store_fire)
        begin
            out_chan_reg   <= chan_reg;
            out_sample_reg <= skip_reg ? '0 : y_reg;
            out_clip_reg   <= !skip_reg && (clip_reg || z1_ovf || z2_ovf);
        end
    end

    // ---------------------------------------------------------------
    // Saturation. y = acc >>> 4 (acc holds the sum >> 24); the new state is
    // {acc, last bit shifted out} (the sum >> 23). Overflow when the bits
    // above the field's sign bit do not all match it.
    // ---------------------------------------------------------------
    always_comb
    begin
        y_top  = acc_a[AW_ACC-1:SW+3];
        y_ovf  = !((&y_top) || !(|y_top));
        y_sat  = y_ovf ? {acc_a[AW_ACC-1], {(SW-1){!acc_a[AW_ACC-1]}}}
                       : acc_a[SW+3:4];

        z1_top = acc_a[AW_ACC-1:ZW-2];
        z1_ovf = !((&z1_top) || !(|z1_top));
        z1_sat = z1_ovf ? {acc_a[AW_ACC-1], {(ZW-1){!acc_a[AW_ACC-1]}}}
                        : {acc_a[ZW-2:0], low_a};

        z2_top = acc_b[AW_ACC-1:ZW-2];
        z2_ovf = !((&z2_top) || !(|z2_top));
        z2_sat = z2_ovf ? {acc_b[AW_ACC-1], {(ZW-1){!acc_b[AW_ACC-1]}}}
                        : {acc_b[ZW-2:0], low_b};
    end

    bq_serial_mac u_mac_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_a_ctrl),
        .coef_x  (coef_a_x),
        .coef_y  (coef_a_y),
        .extra   (extra_a),
        .acc     (acc_a),
        .low_bit (low_a)
    );

    bq_serial_mac u_mac_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_b_ctrl),
        .coef_x  (coef_feed_2_reg),
        .coef_y  (coef_back_2_reg),
        .extra   (extra_b),
        .acc     (acc_b),
        .low_bit (low_b)
    );

    // Delay pairs: z2 in the upper half, z1 in the lower half
    bq_ram #(
        .WIDTH (2 * ZW),
        .DEPTH (CHANNELS)
    ) u_delay_ram (
        .clk   (clk),
        .we    (store_fire && !skip_reg),
        .waddr (st_addr),
        .wdata ({z2_sat, z1_sat}),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    assign sample_ch.ready        = in_ready;
    assign result_ch.valid        = out_valid_reg;
    assign result_ch.data.out_chan   = out_chan_reg;
    assign result_ch.data.out_sample = out_sample_reg;
    assign result_ch.data.clipped    = out_clip_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_result_from_store: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == bq_pkg::ST_STORE))
        else $error("result appeared without a store step");

    a_accept_path: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == bq_pkg::ST_LOAD || state_reg == bq_pkg::ST_STORE))
        else $error("accepted item did not enter load or store");

    a_serial_pass_length: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == bq_pkg::ST_FEED || state_reg == bq_pkg::ST_BACK)
            && state_next != state_reg) |-> last_bit)
        else $error("serial pass ended before all sample bits");

    a_oor_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (store_fire && skip_reg) |=> (out_sample_reg == '0 && !out_clip_reg))
        else $error("out-of-range channel produced a nonzero result");
endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the per-channel biquad filter: random traffic, stalls, checks.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // Fixed run parameters: channel and coefficient counts, idle rate, end-of-run drain, phase sizes.
    localparam int CHANNELS      = bq_pkg::CHANNELS_DEF;
    localparam int COEF_COUNT    = 5;
    localparam int IDLE_PCT      = 15;
    localparam int TAIL_CYCLES   = 60;
    localparam int PHASE_ITEMS   = 180;
    localparam int RANDOM_PHASES = 8;

    // Saturation bounds and rounding offsets of the Q0.23 output and Q3.28 state.
    localparam longint SAMPLE_HI = (longint'(1) <<< (bq_pkg::SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_LO = -(longint'(1) <<< (bq_pkg::SAMPLE_W - 1));
    localparam longint STATE_HI  = (longint'(1) <<< (bq_pkg::STATE_W - 1)) - 1;
    localparam longint STATE_LO  = -(longint'(1) <<< (bq_pkg::STATE_W - 1));
    localparam longint ROUND_OUT = longint'(1) <<< 27;
    localparam longint ROUND_Z   = longint'(1) <<< 22;

    localparam logic [bq_pkg::SAMPLE_W-1:0] SAMPLE_MAX_BITS = 24'h7F_FFFF;
    localparam logic [bq_pkg::SAMPLE_W-1:0] SAMPLE_MIN_BITS = 24'h80_0000;
    localparam logic [bq_pkg::COEF_W-1:0]   COEF_MAX_BITS   = 32'h7FFF_FFFF;
    localparam logic [bq_pkg::COEF_W-1:0]   COEF_MIN_BITS   = 32'h8000_0000;

    // Coefficient styles for the random phases.
    typedef enum int {
        MODE_GENTLE,
        MODE_WILD,
        MODE_CORNER
    } coef_mode_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_wr_en;
    logic [bq_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bq_pkg::COEF_W-1:0]    cfg_data;

    bq_stream_if #(.payload_t(bq_pkg::bq_in_t))  sample_ch ();
    bq_stream_if #(.payload_t(bq_pkg::bq_out_t)) result_ch ();

    biquad_iir_filter #(
        .CHANNELS (CHANNELS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_ch (sample_ch),
        .result_ch (result_ch)
    );

    // Shadow copy of the filter: coefficients and both delay lines per channel.
    logic signed [bq_pkg::COEF_W-1:0]  coef_model      [COEF_COUNT];
    logic signed [bq_pkg::STATE_W-1:0] delay_one_model [CHANNELS] = '{default: '0};
    logic signed [bq_pkg::STATE_W-1:0] delay_two_model [CHANNELS] = '{default: '0};

    bq_pkg::bq_in_t  pending_samples  [$];
    bq_pkg::bq_out_t expected_results [$];

    bit steady_flow;
    int mismatch_count;
    int results_seen;
    int clipped_seen;
    int samples_sent;
    int settings_used;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Clamp to [lo, hi] and flag the hit.
    function automatic longint saturate(longint v, longint lo, longint hi, inout bit hit);
        if (v > hi)
        begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // Compute the filtered sample for one item and advance that channel's delay pair.
    // Products are exact in Q.51; arithmetic shift right gives the floor division.
    function automatic bq_pkg::bq_out_t predict_filter(bq_pkg::bq_in_t item);
        longint          x;
        longint          acc;
        longint          y;
        longint          z1_next;
        longint          z2_next;
        bit              hit;
        bq_pkg::bq_out_t res;
        res          = '0;
        res.out_chan = item.chan_index;
        hit          = 1'b0;
        // A channel beyond the delay memory touches no state and returns silence.
        if (item.chan_index >= CHANNELS)
            return res;
        x   = longint'(item.in_sample);
        acc = x * coef_model[bq_pkg::CFG_FEED_0]
            + (longint'(delay_one_model[item.chan_index]) <<< 23);
        y   = saturate((acc + ROUND_OUT) >>> 28, SAMPLE_LO, SAMPLE_HI, hit);
        // Feedback uses the saturated output.
        acc = x * coef_model[bq_pkg::CFG_FEED_1]
            + (longint'(delay_two_model[item.chan_index]) <<< 23)
            - longint'(coef_model[bq_pkg::CFG_BACK_1]) * y;
        z1_next = saturate((acc + ROUND_Z) >>> 23, STATE_LO, STATE_HI, hit);
        acc = x * coef_model[bq_pkg::CFG_FEED_2]
            - longint'(coef_model[bq_pkg::CFG_BACK_2]) * y;
        z2_next = saturate((acc + ROUND_Z) >>> 23, STATE_LO, STATE_HI, hit);
        delay_one_model[item.chan_index] = bq_pkg::STATE_W'(z1_next);
        delay_two_model[item.chan_index] = bq_pkg::STATE_W'(z2_next);
        res.out_sample = bq_pkg::SAMPLE_W'(y);
        res.clipped    = hit;
        return res;
    endfunction

    // Sender: hold the item until accepted, predict on acceptance, idle at random.
    always @(posedge clk)
    begin : sample_driver
        bq_pkg::bq_in_t next_item;
        bit             load;
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
            sample_ch.data  <= '0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
                expected_results.push_back(predict_filter(sample_ch.data));
            if (!sample_ch.valid || sample_ch.ready)
            begin
                load = pending_samples.size() != 0
                    && (steady_flow || $urandom_range(99) >= IDLE_PCT);
                if (load)
                begin
                    next_item = pending_samples.pop_front();
                    sample_ch.valid <= 1'b1;
                    sample_ch.data  <= next_item;
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random, compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin : result_monitor
        bq_pkg::bq_out_t want;
        bq_pkg::bq_out_t got;
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got = result_ch.data;
                results_seen++;
                if (got.clipped)
                    clipped_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $display({"%0t: unexpected result, expected none, ",
                              "got chan %0d sample %0d clipped %0b"},
                             $time, got.out_chan, got.out_sample, got.clipped);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.out_chan !== want.out_chan || got.out_sample !== want.out_sample
                        || got.clipped !== want.clipped)
                    begin
                        mismatch_count++;
                        $display({"%0t: result mismatch, expected chan %0d sample %0d ",
                                  "clipped %0b, got chan %0d sample %0d clipped %0b"},
                                 $time, want.out_chan, want.out_sample, want.clipped,
                                 got.out_chan, got.out_sample, got.clipped);
                    end
                end
            end
            result_ch.ready <= steady_flow || $urandom_range(99) >= IDLE_PCT;
        end
    end

    // Queue one item for the sender.
    task automatic push_sample(int chan, logic [bq_pkg::SAMPLE_W-1:0] value);
        bq_pkg::bq_in_t item;
        item.chan_index = bq_pkg::CHAN_W'(chan);
        item.in_sample  = value;
        pending_samples.push_back(item);
        samples_sent++;
    endtask

    // Write one register; out-of-range indexes are dropped by the block and here.
    task automatic write_coef(logic [bq_pkg::CFG_IDX_W-1:0] idx,
                              logic [bq_pkg::COEF_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx <= bq_pkg::CFG_BACK_2)
            coef_model[idx] = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Wait until every queued item is sent and every result is back.
    task automatic wait_idle();
        while (pending_samples.size() != 0 || sample_ch.valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [bq_pkg::COEF_W-1:0] pick_coef(coef_mode_t mode);
        int v;
        case (mode)
            MODE_GENTLE:
            begin
                // Within +/-2.0 in Q3.28: typical audio filter range.
                v = int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
                return bq_pkg::COEF_W'(v);
            end
            MODE_WILD:
                return $urandom;
            default:
                case ($urandom_range(3))
                    0:       return COEF_MAX_BITS;
                    1:       return COEF_MIN_BITS;
                    2:       return '0;
                    default: return $urandom;
                endcase
        endcase
    endfunction

    function automatic logic [bq_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(15))
            0:       return SAMPLE_MAX_BITS;
            1:       return SAMPLE_MIN_BITS;
            2:       return '0;
            3:       return bq_pkg::SAMPLE_W'($urandom_range(0, 2047)) - 24'd1024;
            default: return bq_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic set_all_coefs(logic [bq_pkg::COEF_W-1:0] value);
        for (int i = 0; i < COEF_COUNT; i++)
            write_coef(bq_pkg::CFG_IDX_W'(i), value);
        settings_used++;
    endtask

    initial
    begin
        coef_mode_t mode;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        rst_n          = 1'b0;
        steady_flow    = 1'b0;
        mismatch_count = 0;
        results_seen   = 0;
        clipped_seen   = 0;
        samples_sent   = 0;
        settings_used  = 1;
        coef_model[bq_pkg::CFG_FEED_0] = bq_pkg::FEED_0_RESET;
        for (int i = 1; i < COEF_COUNT; i++)
            coef_model[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Unity gain after reset: the sample passes straight through on every channel.
        push_sample(0, '0);
        push_sample(1, SAMPLE_MAX_BITS);
        push_sample(2, SAMPLE_MIN_BITS);
        push_sample(3, 24'hFF_FFFF);
        push_sample(4, 24'h00_0001);
        push_sample(5, 24'h55_5555);
        push_sample(6, 24'hAA_AAAA);
        push_sample(7, SAMPLE_MAX_BITS);
        wait_idle();

        // Largest positive coefficients: drive the output and both delays into saturation.
        set_all_coefs(COEF_MAX_BITS);
        push_sample(0, SAMPLE_MAX_BITS);
        push_sample(0, SAMPLE_MIN_BITS);
        push_sample(0, SAMPLE_MAX_BITS);
        push_sample(1, 24'h00_0001);
        push_sample(1, '0);
        wait_idle();

        // Most negative coefficients: saturate toward the other rail.
        set_all_coefs(COEF_MIN_BITS);
        push_sample(2, SAMPLE_MAX_BITS);
        push_sample(2, SAMPLE_MIN_BITS);
        push_sample(3, 24'hFF_FFFF);
        push_sample(0, SAMPLE_MIN_BITS);
        wait_idle();

        // Back to pass-through, then hit the spare register indexes, which must be ignored.
        write_coef(bq_pkg::CFG_FEED_0, bq_pkg::FEED_0_RESET);
        set_all_coefs('0);
        write_coef(bq_pkg::CFG_FEED_0, bq_pkg::FEED_0_RESET);
        for (int i = COEF_COUNT; i < (1 << bq_pkg::CFG_IDX_W); i++)
            write_coef(bq_pkg::CFG_IDX_W'(i), $urandom);
        push_sample(0, 24'h12_3456);
        push_sample(2, SAMPLE_MIN_BITS);
        push_sample(3, SAMPLE_MAX_BITS);
        wait_idle();

        // Random phases: new coefficients each time, channels interleaved at random.
        // Each phase stops halfway until all results are back, so the block fully drains.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            mode = coef_mode_t'(p % 3);
            for (int i = 0; i < COEF_COUNT; i++)
                write_coef(bq_pkg::CFG_IDX_W'(i), pick_coef(mode));
            settings_used++;
            steady_flow = (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    wait_idle();
                push_sample($urandom_range(CHANNELS - 1), pick_sample());
            end
            wait_idle();
        end
        steady_flow = 1'b0;

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d samples under %0d coefficient settings on %0d channels",
                 samples_sent, settings_used, CHANNELS);
        $display("%0d results checked, %0d saturated, %0d mismatches",
                 results_seen, clipped_seen, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: several times the slowest expected run.
    initial
    begin
        #5_000_000;
        $display("watchdog expired with %0d results outstanding", expected_results.size());
        $display("tb: failure");
        $finish;
    end

endmodule
